// ===== sv/bfmd_pkg.sv =====
package bfmd_pkg;

	localparam int MAX_WIDTH  = 4096;
	localparam int CFG_W      = 13;
	localparam int CFG_IDX_W  = 2;
	localparam int DIM_W      = $clog2(MAX_WIDTH + 1);
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int LINE_DEPTH = MAX_WIDTH / 2;
	localparam int ADDR_W     = (LINE_DEPTH > 1) ? $clog2(LINE_DEPTH) : 1;
	localparam int CHAN_W     = 8;
	localparam int PAIR_W     = CHAN_W + 1;
	localparam int SUM_W      = CHAN_W + 2;
	localparam int NUM_CHAN   = 4;
	localparam int LINE_W     = NUM_CHAN * PAIR_W;
	localparam int QDEPTH     = 4;
	localparam int QPTR_W     = $clog2(QDEPTH);
	localparam int FILL_W     = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] REG_SRC_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_SRC_HEIGHT = CFG_IDX_W'(1);

	typedef logic [CHAN_W-1:0] chan_t;
	typedef logic [PAIR_W-1:0] pair_t;
	typedef pair_t [NUM_CHAN-1:0] line_t;
	typedef chan_t [NUM_CHAN-1:0] pixel_t;

	typedef struct packed {
		logic  valid;
		logic  dbl;
		logic  done;
		line_t pair;
	} item_t;

	typedef struct packed {
		logic                     we;
		logic                     re;
		logic [ADDR_W-1:0]        addr;
		logic [LINE_W-1:0]        wdata;
	} line_req_t;

	typedef struct packed {
		pixel_t pix;
		logic   done;
	} result_t;

	function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
		logic [DIM_W-1:0] r;
		if (v == '0) begin
			r = DIM_W'(1);
		end else if (int'(v) > MAX_WIDTH) begin
			r = DIM_W'(MAX_WIDTH);
		end else begin
			r = DIM_W'(v);
		end
		return r;
	endfunction

endpackage

// ===== sv/bfmd_ram.sv =====
module bfmd_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== sv/bfmd_front.sv =====
module bfmd_front (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bfmd_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [bfmd_pkg::CFG_W-1:0]         cfg_data,
	input  logic                               in_valid,
	output logic                               in_stall,
	input  bfmd_pkg::pixel_t                   pix,
	input  logic [bfmd_pkg::FILL_W-1:0]        fill,
	output bfmd_pkg::line_req_t                line_req,
	output bfmd_pkg::item_t                    item_s1
);
	import bfmd_pkg::*;

	logic [DIM_W-1:0]  w_q;
	logic [DIM_W-1:0]  h_q;
	logic [COL_W-1:0]  col_q;
	logic [COL_W-1:0]  row_q;
	pixel_t            held_q;

	logic              accept;
	logic              w1;
	logic              h1;
	logic              last_col;
	logic              last_row;
	logic [ADDR_W-1:0] dx;
	logic [ADDR_W-1:0] dy;
	logic [ADDR_W-1:0] dwm1;
	logic [ADDR_W-1:0] dhm1;
	logic              have_pair;
	logic              emit;
	logic              done;
	line_t             pair;

	assign cfg_ready = 1'b1;
	assign in_stall  = (fill + FILL_W'(item_s1.valid)) >= FILL_W'(QDEPTH);
	assign accept    = in_valid & ~in_stall;

	assign w1       = (w_q == DIM_W'(1));
	assign h1       = (h_q == DIM_W'(1));
	assign last_col = (DIM_W'(col_q) == w_q - DIM_W'(1));
	assign last_row = (DIM_W'(row_q) == h_q - DIM_W'(1));
	assign dx       = ADDR_W'(col_q >> 1);
	assign dy       = ADDR_W'(row_q >> 1);
	assign dwm1     = w1 ? '0 : ADDR_W'((w_q >> 1) - DIM_W'(1));
	assign dhm1     = h1 ? '0 : ADDR_W'((h_q >> 1) - DIM_W'(1));

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			pair[c] = w1 ? {pix[c], 1'b0} : PAIR_W'(held_q[c]) + PAIR_W'(pix[c]);
		end
	end

	assign have_pair = w1 | col_q[0];
	assign emit      = have_pair & (h1 | row_q[0]);
	assign done      = (dx == dwm1) & (h1 | (dy == dhm1));

	// even rows park their pair sums, odd rows fetch them back
	assign line_req.we    = accept & have_pair & ~h1 & ~row_q[0] & ~last_row;
	assign line_req.re    = accept & have_pair & ~h1 & row_q[0];
	assign line_req.addr  = dx;
	assign line_req.wdata = pair;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			w_q     <= DIM_W'(1);
			h_q     <= DIM_W'(1);
			col_q   <= '0;
			row_q   <= '0;
			held_q  <= '0;
			item_s1 <= '0;
		end else begin
			item_s1.valid <= accept & emit;
			if (accept) begin
				item_s1.dbl  <= h1;
				item_s1.done <= done;
				item_s1.pair <= pair;
			end
			if (cfg_valid && cfg_ready) begin
				if (cfg_index == REG_SRC_WIDTH) begin
					w_q <= clamp_dim(cfg_data);
				end else if (cfg_index == REG_SRC_HEIGHT) begin
					h_q <= clamp_dim(cfg_data);
				end
				col_q <= '0;
				row_q <= '0;
			end else if (accept) begin
				if (!w1 && !col_q[0]) begin
					held_q <= pix;
				end
				if (last_col) begin
					col_q <= '0;
					row_q <= last_row ? '0 : row_q + COL_W'(1);
				end else begin
					col_q <= col_q + COL_W'(1);
				end
			end
		end
	end

endmodule

// ===== sv/bfmd_back.sv =====
module bfmd_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  bfmd_pkg::item_t               item_s1,
	input  logic [bfmd_pkg::LINE_W-1:0]   line_rdata,
	output logic [bfmd_pkg::FILL_W-1:0]   fill,
	output logic                          out_valid,
	input  logic                          out_stall,
	output bfmd_pkg::result_t             result
);
	import bfmd_pkg::*;

	result_t           fifo_q [QDEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [FILL_W-1:0] fill_q;

	line_t             above;
	result_t           res;
	logic [SUM_W-1:0]  sum [NUM_CHAN];
	logic              push;
	logic              pop;

	assign above = line_rdata;

	always_comb begin
		for (int c = 0; c < NUM_CHAN; c++) begin
			sum[c] = item_s1.dbl ? {item_s1.pair[c], 1'b0}
				: SUM_W'(above[c]) + SUM_W'(item_s1.pair[c]);
			res.pix[c] = sum[c][SUM_W-1:2];
		end
		res.done = item_s1.done;
	end

	assign push      = item_s1.valid;
	assign out_valid = (fill_q != '0);
	assign pop       = out_valid & ~out_stall;
	assign fill      = fill_q;
	assign result    = fifo_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
			end
			case ({push, pop})
				2'b10:   fill_q <= fill_q + FILL_W'(1);
				2'b01:   fill_q <= fill_q - FILL_W'(1);
				default: fill_q <= fill_q;
			endcase
		end
	end

endmodule

// ===== sv/box_filter_mip_downsample.sv =====
// 2x2 box-filter mip downsampler for raster-order RGBA8 pixels. One source pixel is taken
// every clock while in_stall is low; a destination pixel leaves after the source pixel that
// completes its block, via the item_s1 register and a four-entry result queue, so the input
// keeps flowing while up to three results wait at a stalled output. Horizontal pair sums of
// even rows sit in a 2048 x 36 line RAM with one write and one registered read port; entries
// are not cleared after reset since each is written before it is read. Program src_width and
// src_height (register 0 and 1) only while the block is idle: every write restarts the
// image. Odd last columns and rows are dropped, a size of one is mirrored, and
// level_done marks the final pixel of the level.
module box_filter_mip_downsample (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [bfmd_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [bfmd_pkg::CFG_W-1:0]     cfg_data,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [7:0]                     in_red,
	input  logic [7:0]                     in_green,
	input  logic [7:0]                     in_blue,
	input  logic [7:0]                     in_alpha,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [7:0]                     out_red,
	output logic [7:0]                     out_green,
	output logic [7:0]                     out_blue,
	output logic [7:0]                     out_alpha,
	output logic                           level_done
);
	import bfmd_pkg::*;

	pixel_t            pix;
	line_req_t         line_req;
	item_t             item_s1;
	logic [LINE_W-1:0] line_rdata;
	logic [FILL_W-1:0] fill;
	result_t           result;

	assign pix[0] = in_red;
	assign pix[1] = in_green;
	assign pix[2] = in_blue;
	assign pix[3] = in_alpha;

	bfmd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.pix       (pix),
		.fill      (fill),
		.line_req  (line_req),
		.item_s1   (item_s1)
	);

	bfmd_ram #(
		.WIDTH (LINE_W),
		.DEPTH (LINE_DEPTH)
	) u_line (
		.clk   (clk),
		.we    (line_req.we),
		.waddr (line_req.addr),
		.wdata (line_req.wdata),
		.re    (line_req.re),
		.raddr (line_req.addr),
		.rdata (line_rdata)
	);

	bfmd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_s1    (item_s1),
		.line_rdata (line_rdata),
		.fill       (fill),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.result     (result)
	);

	assign out_red    = result.pix[0];
	assign out_green  = result.pix[1];
	assign out_blue   = result.pix[2];
	assign out_alpha  = result.pix[3];
	assign level_done = result.done;

endmodule

// ===== sv/bfmd_checker.sv =====
module bfmd_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           cfg_valid,
	input logic                           cfg_ready,
	input logic                           in_valid,
	input logic                           in_stall,
	input logic                           out_valid,
	input logic                           out_stall,
	input logic [7:0]                     out_red,
	input logic [7:0]                     out_green,
	input logic [7:0]                     out_blue,
	input logic [7:0]                     out_alpha,
	input logic                           level_done
);

	// stalled result request holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(out_red) && $stable(out_green)
			&& $stable(out_blue) && $stable(out_alpha) && $stable(level_done))
		else $error("stalled result changed");

	// config port never back-pressures
	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write refused");

	// a result from an empty queue needs an accepted source pixel behind it
	a_out_latency: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && !in_stall, 2))
		else $error("result without source pixel");

	// input only stalls behind a backed-up output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> out_valid)
		else $error("input stalled while output empty");

endmodule

bind box_filter_mip_downsample bfmd_checker u_bfmd_checker (.*);
